[rtl/ntms_pkg.sv]
package ntms_pkg;

   localparam int MAX_WINDOW = 16;
   localparam int IDX_W      = $clog2(MAX_WINDOW);
   localparam int CNT_W      = $clog2(MAX_WINDOW + 1);

   localparam logic [15:0] LN2_Q16   = 16'd45426;
   localparam logic [16:0] Q16_ONE   = 17'd65536;
   localparam logic [19:0] S_MAX     = 20'hFFFFF;
   localparam logic [25:0] D_MAX     = 26'h3FFFFFF;
   localparam logic [4:0]  K_LIMIT   = 5'd30;
   localparam logic [3:0]  TERMS     = 4'd12;
   localparam logic [36:0] E_LIMIT   = 37'((int'(K_LIMIT) + 1) * int'(LN2_Q16));

   typedef struct packed {
      logic signed [31:0] sample_value;
      logic signed [15:0] template_value;
      logic               last_item;
   } req_type;

   typedef struct packed {
      logic [15:0]        match_score;
      logic signed [31:0] window_minimum;
      logic signed [31:0] window_maximum;
      logic [3:0]         maximum_index;
      logic [3:0]         minimum_index;
      logic [19:0]        shape_term;
      logic [25:0]        slope_term;
      logic               degenerate_flag;
   } rsp_type;

   typedef struct packed {
      logic               store;
      logic               finish;
      logic [IDX_W-1:0]   idx;
      logic signed [31:0] smp;
      logic signed [19:0] tpl;
      logic [CNT_W-1:0]   count;
      logic signed [31:0] min_val;
      logic signed [31:0] max_val;
      logic [IDX_W-1:0]   min_pos;
      logic [IDX_W-1:0]   max_pos;
   } cmd_type;

endpackage

[rtl/ntms_front.sv]
module ntms_front
   import ntms_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    accept,
   input  req_type req,
   output logic    cmd_push,
   output cmd_type cmd
);

   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic signed [31:0] min_ff, min_in, max_ff, max_in;
   logic [IDX_W-1:0]   minpos_ff, minpos_in, maxpos_ff, maxpos_in;
   logic               stored;
   logic signed [31:0] nmin, nmax;
   logic [IDX_W-1:0]   nminpos, nmaxpos;

   always_comb begin
      stored  = fill_ff < CNT_W'(MAX_WINDOW);
      nmin    = min_ff;
      nmax    = max_ff;
      nminpos = minpos_ff;
      nmaxpos = maxpos_ff;
      if (stored) begin
         if (fill_ff == '0) begin
            nmin    = req.sample_value;
            nmax    = req.sample_value;
            nminpos = '0;
            nmaxpos = '0;
         end else begin
            if (req.sample_value > max_ff) begin
               nmax    = req.sample_value;
               nmaxpos = fill_ff[IDX_W-1:0];
            end
            if (req.sample_value < min_ff) begin
               nmin    = req.sample_value;
               nminpos = fill_ff[IDX_W-1:0];
            end
         end
      end
      cmd.store   = stored;
      cmd.finish  = req.last_item;
      cmd.idx     = fill_ff[IDX_W-1:0];
      cmd.smp     = req.sample_value;
      cmd.tpl     = {req.template_value, 4'b0000};
      cmd.count   = fill_ff + CNT_W'(stored);
      cmd.min_val = nmin;
      cmd.max_val = nmax;
      cmd.min_pos = nminpos;
      cmd.max_pos = nmaxpos;
      cmd_push    = accept && (stored || req.last_item);

      fill_in   = fill_ff;
      min_in    = min_ff;
      max_in    = max_ff;
      minpos_in = minpos_ff;
      maxpos_in = maxpos_ff;
      if (accept) begin
         if (req.last_item) begin
            fill_in   = '0;
            min_in    = '0;
            max_in    = '0;
            minpos_in = '0;
            maxpos_in = '0;
         end else begin
            fill_in   = cmd.count;
            min_in    = nmin;
            max_in    = nmax;
            minpos_in = nminpos;
            maxpos_in = nmaxpos;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         min_ff    <= '0;
         max_ff    <= '0;
         minpos_ff <= '0;
         maxpos_ff <= '0;
      end else begin
         fill_ff   <= fill_in;
         min_ff    <= min_in;
         max_ff    <= max_in;
         minpos_ff <= minpos_in;
         maxpos_ff <= maxpos_in;
      end
   end

endmodule

[rtl/ntms_queue.sv]
module ntms_queue
   import ntms_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type din,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output cmd_type dout
);

   cmd_type    slot_ff [2];
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full  = cnt_ff == 2'd2;
   assign empty = cnt_ff == 2'd0;
   assign dout  = slot_ff[rd_ff];

   always_comb begin
      rd_in  = rd_ff ^ (pop && !empty);
      wr_in  = wr_ff ^ (push && !full);
      cnt_in = cnt_ff + 2'(push && !full) - 2'(pop && !empty);
   end

   always_ff @(posedge clock) begin
      if (push && !full) slot_ff[wr_ff] <= din;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
         cnt_ff <= cnt_in;
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("transfer into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset) !(pop && empty))
      else $error("pop from empty queue");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff <= 2'd2) && ((cnt_ff == 2'd1) == (rd_ff != wr_ff)))
      else $error("queue pointers and count disagree");

endmodule

[rtl/ntms_div.sv]
module ntms_div
   import ntms_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [36:0] dividend,
   input  logic [15:0] divisor,
   output logic        done,
   output logic [36:0] quotient
);

   logic [36:0] dvd_ff, dvd_in;
   logic [15:0] rem_ff, rem_in, dsr_ff, dsr_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        done_ff, done_in;
   logic [16:0] remx;

   assign done      = done_ff;
   assign quotient  = dvd_ff;

   always_comb begin
      remx    = {rem_ff, dvd_ff[36]};
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in = dividend;
         dsr_in = divisor;
         rem_in = '0;
         cnt_in = 6'd37;
      end else if (cnt_ff != '0) begin
         if (remx >= {1'b0, dsr_ff}) begin
            rem_in = 16'(remx - {1'b0, dsr_ff});
            dvd_in = {dvd_ff[35:0], 1'b1};
         end else begin
            rem_in = remx[15:0];
            dvd_in = {dvd_ff[35:0], 1'b0};
         end
         cnt_in  = cnt_ff - 6'd1;
         done_in = cnt_ff == 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

endmodule

[rtl/ntms_back.sv]
module ntms_back
   import ntms_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_empty,
   input  cmd_type cmd,
   output logic    cmd_pop,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   typedef enum logic [18:0] {
      ST_IDLE   = 19'b0000000000000000001,
      ST_LOAD   = 19'b0000000000000000010,
      ST_DIVSET = 19'b0000000000000000100,
      ST_DIVX   = 19'b0000000000000001000,
      ST_SQSET  = 19'b0000000000000010000,
      ST_SQRT   = 19'b0000000000000100000,
      ST_GRAD   = 19'b0000000000001000000,
      ST_MEAN_S = 19'b0000000000010000000,
      ST_WAIT_S = 19'b0000000000100000000,
      ST_MEAN_D = 19'b0000000001000000000,
      ST_WAIT_D = 19'b0000000010000000000,
      ST_SQ     = 19'b0000000100000000000,
      ST_EK     = 19'b0000001000000000000,
      ST_WAIT_K = 19'b0000010000000000000,
      ST_TMUL   = 19'b0000100000000000000,
      ST_TDIV   = 19'b0001000000000000000,
      ST_TWAIT  = 19'b0010000000000000000,
      ST_ROUND  = 19'b0100000000000000000,
      ST_OUT    = 19'b1000000000000000000
   } state_type;

   state_type state_ff, state_in;

   logic signed [31:0] smp_mem [MAX_WINDOW];
   logic signed [19:0] tpl_mem [MAX_WINDOW];

   logic [CNT_W-1:0]   n_ff, n_in, i_ff, i_in;
   logic signed [31:0] min_ff, min_in, max_ff, max_in;
   logic [IDX_W-1:0]   minpos_ff, minpos_in, maxpos_ff, maxpos_in;
   logic [31:0]        span_ff, span_in;
   logic               degen_ff, degen_in;
   logic signed [31:0] rd_smp_ff;
   logic signed [19:0] rd_tpl_ff;
   logic [32:0]        r_ff, r_in;
   logic [16:0]        q_ff, q_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic [37:0]        op_ff, op_in;
   logic [21:0]        rem_ff, rem_in;
   logic [18:0]        root_ff, root_in;
   logic [22:0]        gv_ff, gv_in;
   logic [16:0]        xprev_ff, xprev_in;
   logic signed [19:0] tprev_ff, tprev_in;
   logic [23:0]        ssum_ff, ssum_in;
   logic [30:0]        dsum_ff, dsum_in;
   logic [19:0]        s_ff, s_in;
   logic [25:0]        d_ff, d_in;
   logic [23:0]        ss_ff, ss_in;
   logic [35:0]        dd_ff, dd_in;
   logic [4:0]         k_ff, k_in;
   logic [29:0]        r30_ff, r30_in;
   logic [30:0]        term_ff, term_in;
   logic signed [32:0] sum_ff, sum_in;
   logic [3:0]         ti_ff, ti_in;
   logic [60:0]        prod_ff, prod_in;
   logic [15:0]        score_ff, score_in;
   logic               valid_ff, valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               div_start, div_done;
   logic [36:0]        div_dvd, div_q;
   logic [15:0]        div_dsr;

   logic [31:0]        a_off;
   logic signed [21:0] diff;
   logic [21:0]        av;
   logic signed [22:0] gd;
   logic [22:0]        gabs;
   logic [33:0]        r2;
   logic [21:0]        remx, trial;
   logic [31:0]        sp;
   logic [44:0]        rnd;
   logic [44:0]        res;
   logic [5:0]         sh;
   logic [36:0]        e_sum;
   logic [37:0]        ln_step;

   ntms_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dvd),
      .divisor   (div_dsr),
      .done      (div_done),
      .quotient  (div_q)
   );

   assign rsp_empty = !valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      div_start = 1'b0;
      div_dvd   = '0;
      div_dsr   = '0;
      case (state_ff)
         ST_MEAN_S: begin
            div_start = 1'b1;
            div_dvd   = 37'(ssum_ff);
            div_dsr   = 16'(n_ff);
         end
         ST_MEAN_D: begin
            div_start = 1'b1;
            div_dvd   = 37'(dsum_ff);
            div_dsr   = 16'(n_ff - CNT_W'(1));
         end
         ST_TDIV: begin
            div_start = 1'b1;
            div_dvd   = 37'(prod_ff[60:30]);
            div_dsr   = 16'(ti_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && !cmd_empty && cmd.store) begin
         smp_mem[cmd.idx] <= cmd.smp;
         tpl_mem[cmd.idx] <= cmd.tpl;
      end
      if (state_ff == ST_LOAD) begin
         rd_smp_ff <= smp_mem[i_ff[IDX_W-1:0]];
         rd_tpl_ff <= tpl_mem[i_ff[IDX_W-1:0]];
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd_pop   = 1'b0;
      n_in      = n_ff;
      i_in      = i_ff;
      min_in    = min_ff;
      max_in    = max_ff;
      minpos_in = minpos_ff;
      maxpos_in = maxpos_ff;
      span_in   = span_ff;
      degen_in  = degen_ff;
      r_in      = r_ff;
      q_in      = q_ff;
      cnt_in    = cnt_ff;
      op_in     = op_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      gv_in     = gv_ff;
      xprev_in  = xprev_ff;
      tprev_in  = tprev_ff;
      ssum_in   = ssum_ff;
      dsum_in   = dsum_ff;
      s_in      = s_ff;
      d_in      = d_ff;
      ss_in     = ss_ff;
      dd_in     = dd_ff;
      k_in      = k_ff;
      r30_in    = r30_ff;
      term_in   = term_ff;
      sum_in    = sum_ff;
      ti_in     = ti_ff;
      prod_in   = prod_ff;
      score_in  = score_ff;
      valid_in  = valid_ff && !rsp_pop;
      rsp_in    = rsp_ff;

      a_off = 32'(33'(rd_smp_ff) - 33'(min_ff));
      diff  = 22'($signed({5'b00000, q_ff})) - 22'(rd_tpl_ff);
      av    = (diff < 0) ? 22'(-diff) : 22'(diff);
      gd    = (23'($signed({6'b000000, q_ff})) - 23'($signed({6'b000000, xprev_ff})))
              - (23'(rd_tpl_ff) - 23'(tprev_ff));
      gabs  = (gd < 0) ? 23'(-gd) : 23'(gd);
      r2    = {r_ff, 1'b0};
      remx  = {rem_ff[19:0], op_ff[37:36]};
      trial = {1'b0, root_ff, 2'b01};
      sp    = (sum_ff < 0) ? 32'd0 : sum_ff[31:0];
      sh    = 6'd14 + 6'(k_ff);
      rnd   = 45'(sp) + (45'd1 << (6'd13 + 6'(k_ff)));
      res   = rnd >> sh;
      e_sum = 37'(ss_ff) + 37'(dd_ff);
      ln_step = 38'(LN2_Q16) << (cnt_ff - 5'd1);

      case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               if (cmd.finish) begin
                  n_in      = cmd.count;
                  min_in    = cmd.min_val;
                  max_in    = cmd.max_val;
                  minpos_in = cmd.min_pos;
                  maxpos_in = cmd.max_pos;
                  span_in   = 32'(33'(cmd.max_val) - 33'(cmd.min_val));
                  degen_in  = (cmd.count < CNT_W'(2)) || (cmd.max_val == cmd.min_val);
                  i_in      = '0;
                  ssum_in   = '0;
                  dsum_in   = '0;
                  state_in  = ST_LOAD;
               end
            end
         end
         ST_LOAD: state_in = ST_DIVSET;
         ST_DIVSET: begin
            if (span_ff == '0) begin
               q_in     = '0;
               state_in = ST_SQSET;
            end else if (a_off == span_ff) begin
               q_in     = Q16_ONE;
               state_in = ST_SQSET;
            end else begin
               q_in     = '0;
               r_in     = 33'(a_off);
               cnt_in   = 5'd16;
               state_in = ST_DIVX;
            end
         end
         ST_DIVX: begin
            if (r2 >= 34'(span_ff)) begin
               r_in = 33'(r2 - 34'(span_ff));
               q_in = {q_ff[15:0], 1'b1};
            end else begin
               r_in = r2[32:0];
               q_in = {q_ff[15:0], 1'b0};
            end
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd1) state_in = ST_SQSET;
         end
         ST_SQSET: begin
            op_in    = {22'(av) + 22'(Q16_ONE), 16'h0000};
            gv_in    = gabs + 23'(Q16_ONE);
            rem_in   = '0;
            root_in  = '0;
            cnt_in   = 5'd19;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            if (remx >= trial) begin
               rem_in  = remx - trial;
               root_in = {root_ff[17:0], 1'b1};
            end else begin
               rem_in  = remx;
               root_in = {root_ff[17:0], 1'b0};
            end
            op_in  = {op_ff[35:0], 2'b00};
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd1) state_in = ST_GRAD;
         end
         ST_GRAD: begin
            ssum_in = ssum_ff + 24'(root_ff);
            if (i_ff != '0) dsum_in = dsum_ff + 31'((46'(gv_ff) * 46'(gv_ff)) >> 16);
            xprev_in = q_ff;
            tprev_in = rd_tpl_ff;
            i_in     = i_ff + CNT_W'(1);
            if (i_ff + CNT_W'(1) == n_ff) state_in = ST_MEAN_S;
            else state_in = ST_LOAD;
         end
         ST_MEAN_S: state_in = ST_WAIT_S;
         ST_WAIT_S: begin
            if (div_done) begin
               if (div_q <= 37'(Q16_ONE)) s_in = '0;
               else if (div_q - 37'(Q16_ONE) > 37'(S_MAX)) s_in = S_MAX;
               else s_in = 20'(div_q - 37'(Q16_ONE));
               if (n_ff > CNT_W'(1)) state_in = ST_MEAN_D;
               else begin
                  d_in     = '0;
                  state_in = ST_SQ;
               end
            end
         end
         ST_MEAN_D: state_in = ST_WAIT_D;
         ST_WAIT_D: begin
            if (div_done) begin
               if (div_q <= 37'(Q16_ONE)) d_in = '0;
               else if (div_q - 37'(Q16_ONE) > 37'(D_MAX)) d_in = D_MAX;
               else d_in = 26'(div_q - 37'(Q16_ONE));
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            ss_in    = 24'((40'(s_ff) * 40'(s_ff)) >> 16);
            dd_in    = 36'((52'(d_ff) * 52'(d_ff)) >> 16);
            state_in = ST_EK;
         end
         ST_EK: begin
            if (e_sum >= E_LIMIT) begin
               score_in = '0;
               state_in = ST_OUT;
            end else begin
               op_in    = 38'(e_sum);
               k_in     = '0;
               cnt_in   = 5'd5;
               state_in = ST_WAIT_K;
            end
         end
         ST_WAIT_K: begin
            if (op_ff >= ln_step) begin
               op_in = op_ff - ln_step;
               k_in  = {k_ff[3:0], 1'b1};
            end else begin
               k_in  = {k_ff[3:0], 1'b0};
            end
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd1) begin
               r30_in   = {op_in[15:0], 14'h0000};
               term_in  = 31'h40000000;
               sum_in   = 33'sh040000000;
               ti_in    = 4'd1;
               state_in = ST_TMUL;
            end
         end
         ST_TMUL: begin
            prod_in  = 61'(term_ff) * 61'(r30_ff);
            state_in = ST_TDIV;
         end
         ST_TDIV: state_in = ST_TWAIT;
         ST_TWAIT: begin
            if (div_done) begin
               term_in = div_q[30:0];
               if (ti_ff[0]) sum_in = sum_ff - $signed({2'b00, div_q[30:0]});
               else sum_in = sum_ff + $signed({2'b00, div_q[30:0]});
               if (ti_ff == TERMS) state_in = ST_ROUND;
               else begin
                  ti_in    = ti_ff + 4'd1;
                  state_in = ST_TMUL;
               end
            end
         end
         ST_ROUND: begin
            score_in = (res > 45'd65535) ? 16'hFFFF : res[15:0];
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!valid_ff || rsp_pop) begin
               valid_in               = 1'b1;
               rsp_in.match_score     = score_ff;
               rsp_in.window_minimum  = min_ff;
               rsp_in.window_maximum  = max_ff;
               rsp_in.maximum_index   = 4'(maxpos_ff);
               rsp_in.minimum_index   = 4'(minpos_ff);
               rsp_in.shape_term      = s_ff;
               rsp_in.slope_term      = d_ff;
               rsp_in.degenerate_flag = degen_ff;
               state_in               = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      n_ff      <= n_in;
      i_ff      <= i_in;
      min_ff    <= min_in;
      max_ff    <= max_in;
      minpos_ff <= minpos_in;
      maxpos_ff <= maxpos_in;
      span_ff   <= span_in;
      degen_ff  <= degen_in;
      r_ff      <= r_in;
      q_ff      <= q_in;
      cnt_ff    <= cnt_in;
      op_ff     <= op_in;
      rem_ff    <= rem_in;
      root_ff   <= root_in;
      gv_ff     <= gv_in;
      xprev_ff  <= xprev_in;
      tprev_ff  <= tprev_in;
      ssum_ff   <= ssum_in;
      dsum_ff   <= dsum_in;
      s_ff      <= s_in;
      d_ff      <= d_in;
      ss_ff     <= ss_in;
      dd_ff     <= dd_in;
      k_ff      <= k_in;
      r30_ff    <= r30_in;
      term_ff   <= term_in;
      sum_ff    <= sum_in;
      ti_ff     <= ti_in;
      prod_ff   <= prod_in;
      score_ff  <= score_in;
      rsp_ff    <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

endmodule

[rtl/normalized_template_match_score.sv]
// Normalized template match score. Samples enter one per cycle while
// req_full is low; the first 16 of a window are stored, and the item marked
// last closes the window and queues it for scoring. Scoring runs on a serial
// engine: per sample a 16-step normalizing divide and a 19-step square root,
// then the two means, a five-step range reduction and the twelve Taylor
// terms of the exponential, the means and terms on one shared 37-step
// divider. Samples of the next window are accepted into a two-entry queue
// meanwhile; req_full rises once it fills. A finished result waits in the
// output register until popped.
module normalized_template_match_score
   import ntms_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   logic    q_full, q_empty, q_pop, f_push;
   cmd_type f_cmd, q_cmd;

   assign req_full = q_full;

   ntms_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (req_push && !q_full),
      .req      (req_data),
      .cmd_push (f_push),
      .cmd      (f_cmd)
   );

   ntms_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (f_push),
      .din   (f_cmd),
      .full  (q_full),
      .pop   (q_pop),
      .empty (q_empty),
      .dout  (q_cmd)
   );

   ntms_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (q_empty),
      .cmd       (q_cmd),
      .cmd_pop   (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

[sim/normalized_template_match_score_tb.sv]
`timescale 1ns / 1ps

module normalized_template_match_score_tb;
   import ntms_pkg::*;

   localparam int CYCLE_LIMIT  = 10000000;
   localparam int DRAIN_CYCLES = 1500;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   logic    req_full;
   req_type req_data = '0;
   logic    rsp_empty;
   logic    rsp_pop = 1'b0;
   rsp_type rsp_data;

   normalized_template_match_score i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // window state of the predictor
   longint  win_sample [MAX_WINDOW];
   longint  win_tmpl [MAX_WINDOW];
   int      win_fill = 0;
   longint  win_min = 0;
   longint  win_max = 0;
   int      win_min_pos = 0;
   int      win_max_pos = 0;
   rsp_type pending_scores [$];

   bit      failed = 1'b0;
   int      cycle_count = 0;
   int      items_sent = 0;
   bit      gaps_on = 1'b1;
   int      burst_left = 0;
   int      hold_cycles = 0;
   int      stall_mode = 0;

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic logic [15:0] neg_exp(longint unsigned e);
      longint unsigned k, r30, term, res;
      longint          acc;
      k = e / 45426;
      r30 = (e - k * 45426) << 14;
      if (k > 30) return 16'd0;
      term = 64'd1 << 30;
      acc = longint'(term);
      for (int i = 1; i <= 12; i++) begin
         term = ((term * r30) >> 30) / i;
         if (i % 2 == 1) acc -= longint'(term);
         else acc += longint'(term);
      end
      if (acc < 0) acc = 0;
      res = (longint'(acc) + (64'd1 << (13 + k))) >> (14 + k);
      return (res > 65535) ? 16'hFFFF : res[15:0];
   endfunction

   task automatic absorb_sample(input req_type it);
      longint          smp, span, a, x [MAX_WINDOW];
      longint unsigned total, mean, v, s, d;
      rsp_type         r;
      smp = it.sample_value;
      if (win_fill < MAX_WINDOW) begin
         win_sample[win_fill] = smp;
         win_tmpl[win_fill] = longint'(it.template_value) * 16;
         if (win_fill == 0) begin
            win_min = smp;
            win_max = smp;
            win_min_pos = 0;
            win_max_pos = 0;
         end else begin
            if (smp > win_max) begin
               win_max = smp;
               win_max_pos = win_fill;
            end
            if (smp < win_min) begin
               win_min = smp;
               win_min_pos = win_fill;
            end
         end
         win_fill++;
      end
      if (!it.last_item) return;
      span = win_max - win_min;
      for (int i = 0; i < win_fill; i++)
         x[i] = (span > 0) ? ((win_sample[i] - win_min) * 65536) / span : 0;
      s = 0;
      if (win_fill > 0) begin
         total = 0;
         for (int i = 0; i < win_fill; i++) begin
            a = x[i] - win_tmpl[i];
            v = ((a < 0) ? -a : a) + 65536;
            total += int_sqrt(v << 16);
         end
         mean = total / win_fill;
         s = (mean > 65536) ? mean - 65536 : 0;
         if (s > S_MAX) s = S_MAX;
      end
      d = 0;
      if (win_fill > 1) begin
         total = 0;
         for (int i = 0; i + 1 < win_fill; i++) begin
            a = (x[i+1] - x[i]) - (win_tmpl[i+1] - win_tmpl[i]);
            v = ((a < 0) ? -a : a) + 65536;
            total += (v * v) >> 16;
         end
         mean = total / (win_fill - 1);
         d = (mean > 65536) ? mean - 65536 : 0;
         if (d > D_MAX) d = D_MAX;
      end
      r.match_score     = neg_exp(((s * s) >> 16) + ((d * d) >> 16));
      r.window_minimum  = win_min[31:0];
      r.window_maximum  = win_max[31:0];
      r.maximum_index   = win_max_pos[3:0];
      r.minimum_index   = win_min_pos[3:0];
      r.shape_term      = s[19:0];
      r.slope_term      = d[25:0];
      r.degenerate_flag = (win_fill < 2) || (span == 0);
      pending_scores.push_back(r);
      win_fill = 0;
      win_min = 0;
      win_max = 0;
      win_min_pos = 0;
      win_max_pos = 0;
   endtask

   task automatic send_item(input logic [31:0] smp, input logic [15:0] tpl, input bit last);
      req_type it;
      int      gap;
      it.sample_value   = smp;
      it.template_value = tpl;
      it.last_item      = last;
      if (gaps_on) begin
         if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            repeat (gap) @(negedge clock) req_push <= 1'b0;
            burst_left = $urandom_range(1, 12);
         end
         burst_left--;
      end
      @(negedge clock);
      req_push <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (req_full);
      absorb_sample(it);
      items_sent++;
   endtask

   task automatic send_window(input int len, input int style);
      logic [31:0] base, smp;
      logic [15:0] tpl;
      base = $urandom;
      for (int i = 0; i < len; i++) begin
         case (style)
            0: smp = $urandom;
            1: smp = base + $urandom_range(0, 1 << 18);
            2: smp = base + ($urandom_range(0, 2) << 16);
            default: smp = $urandom_range(0, 1 << 20);
         endcase
         tpl = (style == 3) ? 16'($urandom_range(0, 4096)) : 16'($urandom);
         send_item(smp, tpl, i == len - 1);
      end
   endtask

   task automatic wait_drained();
      @(negedge clock) req_push <= 1'b0;
      while (pending_scores.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic test_single_sample();
      send_item(32'h0001_8000, 16'h7FFF, 1'b1);
   endtask

   task automatic test_flat_window();
      send_item(32'hFFFF_0000, 16'h8000, 1'b0);
      send_item(32'hFFFF_0000, 16'h0000, 1'b1);
   endtask

   task automatic test_perfect_match();
      send_item(32'h0000_0000, 16'h0000, 1'b0);
      send_item(32'h0001_0000, 16'h1000, 1'b1);
   endtask

   task automatic test_ties_and_extremes();
      send_item(32'h7FFF_FFFF, 16'h7FFF, 1'b0);
      send_item(32'h8000_0000, 16'h8000, 1'b0);
      send_item(32'h7FFF_FFFF, 16'hFFFF, 1'b0);
      send_item(32'h8000_0000, 16'h0001, 1'b1);
   endtask

   task automatic test_full_window();
      for (int i = 0; i < MAX_WINDOW + 1; i++)
         send_item(32'($urandom), 16'($urandom), i == MAX_WINDOW);
   endtask

   task automatic test_random_windows(input int item_goal);
      int len;
      while (items_sent < item_goal) begin
         if ($urandom_range(0, 99) < 4) gaps_on = ~gaps_on;
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
         send_window(len, $urandom_range(0, 3));
      end
      gaps_on = 1'b1;
   endtask

   task automatic test_backpressure();
      hold_cycles = 4000;
      for (int w = 0; w < 4; w++) send_window(8, w);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      test_single_sample();
      test_flat_window();
      test_perfect_match();
      test_ties_and_extremes();
      test_full_window();
      test_random_windows(700);
      test_backpressure();
      wait_drained();
      test_random_windows(1400);
      @(negedge clock) req_push <= 1'b0;
      wait_drained();
      if (!failed)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // receiver: pops results under a randomly re-chosen stall pattern
   always @(negedge clock) begin
      if (cycle_count % 50 == 0) stall_mode = $urandom_range(0, 2);
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_pop <= 1'b0;
      end else begin
         case (stall_mode)
            0: rsp_pop <= 1'b1;
            1: rsp_pop <= $urandom_range(0, 1);
            default: rsp_pop <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_scores.size() == 0) begin
            $error("unexpected result transfer");
            failed = 1'b1;
         end else begin
            want = pending_scores.pop_front();
            if (rsp_data.match_score !== want.match_score) begin
               $error("match_score exp %0d got %0d", want.match_score, rsp_data.match_score);
               failed = 1'b1;
            end
            if (rsp_data.window_minimum !== want.window_minimum) begin
               $error("window_minimum exp %0d got %0d",
                      want.window_minimum, rsp_data.window_minimum);
               failed = 1'b1;
            end
            if (rsp_data.window_maximum !== want.window_maximum) begin
               $error("window_maximum exp %0d got %0d",
                      want.window_maximum, rsp_data.window_maximum);
               failed = 1'b1;
            end
            if (rsp_data.maximum_index !== want.maximum_index) begin
               $error("maximum_index exp %0d got %0d",
                      want.maximum_index, rsp_data.maximum_index);
               failed = 1'b1;
            end
            if (rsp_data.minimum_index !== want.minimum_index) begin
               $error("minimum_index exp %0d got %0d",
                      want.minimum_index, rsp_data.minimum_index);
               failed = 1'b1;
            end
            if (rsp_data.shape_term !== want.shape_term) begin
               $error("shape_term exp %0d got %0d", want.shape_term, rsp_data.shape_term);
               failed = 1'b1;
            end
            if (rsp_data.slope_term !== want.slope_term) begin
               $error("slope_term exp %0d got %0d", want.slope_term, rsp_data.slope_term);
               failed = 1'b1;
            end
            if (rsp_data.degenerate_flag !== want.degenerate_flag) begin
               $error("degenerate_flag exp %0d got %0d",
                      want.degenerate_flag, rsp_data.degenerate_flag);
               failed = 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

endmodule

[filelist.f]
rtl/ntms_pkg.sv
rtl/ntms_front.sv
rtl/ntms_queue.sv
rtl/ntms_div.sv
rtl/ntms_back.sv
rtl/normalized_template_match_score.sv
sim/normalized_template_match_score_tb.sv
